@@ rtl/co2fr_pkg.sv @@
// shared types, constants and helpers of the co2 sensor frame receiver
`timescale 1ns / 1ps

package co2fr_pkg;

	localparam int BYTE_W  = 8;
	localparam int STEP_W  = 13;
	localparam int PPM_W   = 16;
	localparam int LEVEL_W = 4;
	localparam int CNT_W   = 4;
	localparam int BANDS   = 8;

	localparam logic [BYTE_W-1:0] START_RESET   = 8'hFF;
	localparam logic [BYTE_W-1:0] COMMAND_RESET = 8'h86;
	localparam logic [STEP_W-1:0] STEP_RESET    = 13'd375;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_START   = 2'd0;
	localparam cfg_idx_t CFG_COMMAND = 2'd1;
	localparam cfg_idx_t CFG_STEP    = 2'd2;

	// frame hunter states, one-hot
	typedef enum logic [2:0] {
		ST_HUNT = 3'b001,
		ST_CMD  = 3'b010,
		ST_DATA = 3'b100
	} frame_state_t;

	// what the parser reports about the byte on the input port
	typedef struct packed {
		logic                last_slot;
		logic                ok;
		logic [BYTE_W-1:0]   chk;
		logic [PPM_W-1:0]    ppm;
	} frame_end_t;

	// ((b/10)*16 + b%10) mod 256, divide by ten as a reciprocal multiply
	function automatic logic [BYTE_W-1:0] recode(input logic [BYTE_W-1:0] b);
		logic [15:0] prod;
		logic [4:0]  quo;
		logic [7:0]  rem;
		logic [8:0]  sum;
		prod = {8'd0, b} * 16'd205;
		quo  = prod[15:11];
		rem  = b - ({3'd0, quo} * 8'd10);
		sum  = {quo[4:0], 4'b0000} + {1'b0, rem};
		return sum[7:0];
	endfunction

endpackage

@@ rtl/co2fr_parser.sv @@
// frame hunter: start and command match, byte counting, checksum and data capture
`timescale 1ns / 1ps

module co2fr_parser #(
	parameter int FRAME_BYTES = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  co2fr_pkg::cfg_idx_t         cfg_index,
	input  logic [co2fr_pkg::STEP_W-1:0] cfg_wdata,
	input  logic                        accept,
	input  logic [co2fr_pkg::BYTE_W-1:0] rx_byte,
	output co2fr_pkg::frame_end_t       fe
);
	import co2fr_pkg::*;

	localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] HIGH_POS = CNT_W'(2);
	localparam logic [CNT_W-1:0] LOW_POS  = CNT_W'(3);

	frame_state_t       state_q;
	logic [CNT_W-1:0]   count_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [BYTE_W-1:0]  high_q;
	logic [BYTE_W-1:0]  low_q;
	logic [BYTE_W-1:0]  start_q;
	logic [BYTE_W-1:0]  command_q;
	logic [BYTE_W-1:0]  low_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= START_RESET;
			command_q <= COMMAND_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START) start_q <= cfg_wdata[BYTE_W-1:0];
			if (cfg_index == CFG_COMMAND) command_q <= cfg_wdata[BYTE_W-1:0];
		end
	end

	// on short frames the checksum byte doubles as the low byte
	assign low_use = (count_q == LOW_POS) ? recode(rx_byte) : low_q;

	always_comb begin
		fe.last_slot = (state_q == ST_DATA) && (count_q == LAST);
		fe.chk       = BYTE_W'(0) - sum_q;
		fe.ok        = (rx_byte == fe.chk);
		fe.ppm       = {high_q, low_use};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			high_q  <= '0;
			low_q   <= '0;
		end else if (accept) begin
			unique case (state_q)
				ST_CMD: begin
					if (rx_byte == command_q) begin
						state_q <= ST_DATA;
						count_q <= HIGH_POS;
						sum_q   <= rx_byte;
					end else begin
						state_q <= ST_HUNT;
						count_q <= '0;
					end
				end
				ST_DATA: begin
					if (count_q == HIGH_POS) high_q <= recode(rx_byte);
					if (count_q == LOW_POS) low_q <= recode(rx_byte);
					if (count_q < LAST) begin
						sum_q   <= sum_q + rx_byte;
						count_q <= count_q + 1'b1;
					end else begin
						state_q <= ST_HUNT;
						count_q <= '0;
					end
				end
				default: begin
					if (rx_byte == start_q) begin
						state_q <= ST_CMD;
						count_q <= CNT_W'(1);
						sum_q   <= '0;
					end else begin
						state_q <= ST_HUNT;
						count_q <= '0;
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/co2fr_band.sv @@
// level band lookup against thresholds built when the step is written
`timescale 1ns / 1ps

module co2fr_band (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  co2fr_pkg::cfg_idx_t           cfg_index,
	input  logic [co2fr_pkg::STEP_W-1:0]  cfg_wdata,
	input  logic [co2fr_pkg::PPM_W-1:0]   ppm,
	output logic                          hit,
	output logic [co2fr_pkg::LEVEL_W-1:0] level
);
	import co2fr_pkg::*;

	logic [PPM_W-1:0] thr_q [BANDS];
	logic [BANDS-1:0] below;

	for (genvar k = 0; k < BANDS; k++) begin : g_thr
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				thr_q[k] <= PPM_W'(32'(STEP_RESET) * (k + 1));
			end else if (cfg_we && cfg_index == CFG_STEP) begin
				thr_q[k] <= PPM_W'(32'(cfg_wdata) * (k + 1));
			end
		end
		assign below[k] = ppm < thr_q[k];
	end

	// lowest band whose upper edge lies above ppm
	always_comb begin
		hit   = 1'b0;
		level = '0;
		for (int k = BANDS - 1; k >= 0; k--) begin
			if (below[k]) begin
				hit   = 1'b1;
				level = LEVEL_W'(k + 1);
			end
		end
	end

endmodule

@@ rtl/co2_sensor_frame_receiver.sv @@
// top level of the co2 sensor response frame receiver
// a result beat becomes valid in the cycle after the frame's checksum byte is accepted
// throughput: one byte per cycle; bytes that do not end a frame never wait on the output
// a checksum byte waits only while an untaken result sits in the output register
// reset: hunting for a start byte, start/command/step at 0xff/0x86/375, stored ppm and level 0
`timescale 1ns / 1ps

module co2_sensor_frame_receiver #(
	parameter int FRAME_BYTES = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  co2fr_pkg::cfg_idx_t           cfg_index,
	input  logic [co2fr_pkg::STEP_W-1:0]  cfg_wdata,
	// received byte beats
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [co2fr_pkg::BYTE_W-1:0]  rx_byte,
	// result beats
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          frame_ok,
	output logic [co2fr_pkg::PPM_W-1:0]   ppm,
	output logic [co2fr_pkg::LEVEL_W-1:0] level,
	output logic [co2fr_pkg::BYTE_W-1:0]  expected_checksum
);
	import co2fr_pkg::*;

	frame_end_t          fe;
	logic                accept;
	logic                band_hit;
	logic [LEVEL_W-1:0]  band_level;
	logic                frame_done;

	// latest accepted reading, kept across bad frames
	logic [PPM_W-1:0]    last_ppm_q;
	logic [LEVEL_W-1:0]  last_level_q;

	// output register
	logic                out_valid_q;
	logic                frame_ok_q;
	logic [PPM_W-1:0]    ppm_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [BYTE_W-1:0]   chk_q;

	// only a checksum byte needs room in the output register
	assign in_ready   = !fe.last_slot || !out_valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign frame_done = accept && fe.last_slot;

	co2fr_parser #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.fe       (fe)
	);

	co2fr_band u_band (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.ppm      (fe.ppm),
		.hit      (band_hit),
		.level    (band_level)
	);

	// a good frame updates ppm; the level moves only when a band matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ppm_q   <= '0;
			last_level_q <= '0;
		end else if (frame_done && fe.ok) begin
			last_ppm_q <= fe.ppm;
			if (band_hit) last_level_q <= band_level;
		end
	end

	// result beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with the values the frame leaves behind
	always_ff @(posedge clk) begin
		if (frame_done) begin
			frame_ok_q <= fe.ok;
			chk_q      <= fe.chk;
			ppm_q      <= fe.ok ? fe.ppm : last_ppm_q;
			level_q    <= (fe.ok && band_hit) ? band_level : last_level_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign frame_ok          = frame_ok_q;
	assign ppm               = ppm_q;
	assign level             = level_q;
	assign expected_checksum = chk_q;

`ifndef ASSERT_OFF
	// a finished frame always shows up as a result beat
	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> out_valid_q)
		else $error("frame end not followed by a result beat");

	// input stalls only for a checksum byte behind an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid_q && fe.last_slot && !out_ready))
		else $error("input stalled without a blocked result");

	// a good frame reports the reading it stored
	a_ok_ppm: assert property (@(posedge clk) disable iff (!arst_n)
		$past(frame_done && fe.ok) |-> (ppm_q == last_ppm_q))
		else $error("reported ppm differs from stored reading");

	// level stays within the band range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (level_q <= LEVEL_W'(BANDS)))
		else $error("level out of range");
`endif

endmodule
